@@ rtl/core/tlb_pkg.sv @@
// Shared widths, operation codes and controller command type for the TLB block.
`default_nettype none

package tlb_pkg;

   localparam int MODE_W  = 2;
   localparam int PROC_W  = 5;
   localparam int PAGE_W  = 10;
   localparam int FRAME_W = 8;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 6;

   // Entry count is pinned by the slot field width.
   localparam int TLB_ENTRIES  = 32;
   localparam int AGE_BITS_DEF = 16;

   // Oldest-entry search is split into groups scanned in parallel.
   localparam int GRP_SIZE = 8;
   localparam int GROUPS   = TLB_ENTRIES / GRP_SIZE;

   localparam logic [PROC_W-1:0] PROC_NONE = 5'd31;

   localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REFILL     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd2;

   typedef struct packed {
      logic load;    // capture the request transaction
      logic scan;    // compare and group search
      logic commit;  // update entries and load the result
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/tlb_req_if.sv @@
// Request channel: valid/ready with the translation request payload.
`default_nettype none

interface tlb_req_if;
   import tlb_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [PROC_W-1:0]  process_id;
   logic [PAGE_W-1:0]  page_number;
   logic [FRAME_W-1:0] frame_number;

   modport source (output valid, mode, process_id, page_number, frame_number,
                   input ready);
   modport sink (input valid, mode, process_id, page_number, frame_number,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/core/tlb_rsp_if.sv @@
// Response channel: valid/ready with the lookup/refill/invalidate result payload.
`default_nettype none

interface tlb_rsp_if;
   import tlb_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [FRAME_W-1:0] hit_frame;
   logic [SLOT_W-1:0]  slot;
   logic               flushed;
   logic [COUNT_W-1:0] invalidated_count;

   modport source (output valid, hit, hit_frame, slot, flushed, invalidated_count,
                   input ready);
   modport sink (input valid, hit, hit_frame, slot, flushed, invalidated_count,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/core/tlb_lru_lookup_refill.sv @@
// Top level of the 32-entry fully associative TLB with LRU refill.
// Each request transaction (lookup, refill or invalidate-by-frame) passes the
// capture, scan and apply steps: capture of the request, the parallel tag/frame
// compare across all entries plus an oldest-entry search inside groups of eight,
// and then combining the group winners, updating valid bits and ages, and loading the
// response register. A new request is taken only once the last one is applied;
// a finished response may sit in its register while the
// next request is captured and scanned, and the apply step waits only if that
// response is still untaken. A lookup from a process other than that of the last
// lookup flushes the whole buffer and reports flushed. No clearing pass follows
// reset; the block is ready in the first cycle after reset drops.
`default_nettype none

module tlb_lru_lookup_refill #(
   parameter int AGE_BITS = tlb_pkg::AGE_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   tlb_req_if.sink    req_if,
   tlb_rsp_if.source  rsp_if
);
   import tlb_pkg::*;

   cmd_type cmd;

   tlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   tlb_dpath #(
      .AGE_BITS (AGE_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_mode              (req_if.mode),
      .req_process_id        (req_if.process_id),
      .req_page_number       (req_if.page_number),
      .req_frame_number      (req_if.frame_number),
      .rsp_hit               (rsp_if.hit),
      .rsp_hit_frame         (rsp_if.hit_frame),
      .rsp_slot              (rsp_if.slot),
      .rsp_flushed           (rsp_if.flushed),
      .rsp_invalidated_count (rsp_if.invalidated_count)
   );

endmodule

`default_nettype wire

@@ rtl/core/tlb_ctrl.sv @@
// Sequencer for the TLB: capture, scan, apply, and the response valid flag.
`default_nettype none

module tlb_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output tlb_pkg::cmd_type     cmd
);
   import tlb_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tlb_dpath.sv @@
// TLB datapath: entry registers, parallel tag compare, LRU search, update and result register.
`default_nettype none

module tlb_dpath #(
   parameter int AGE_BITS = tlb_pkg::AGE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tlb_pkg::cmd_type              cmd,
   input  wire logic [tlb_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [tlb_pkg::PROC_W-1:0]    req_process_id,
   input  wire logic [tlb_pkg::PAGE_W-1:0]    req_page_number,
   input  wire logic [tlb_pkg::FRAME_W-1:0]   req_frame_number,
   output logic                               rsp_hit,
   output logic [tlb_pkg::FRAME_W-1:0]        rsp_hit_frame,
   output logic [tlb_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_flushed,
   output logic [tlb_pkg::COUNT_W-1:0]        rsp_invalidated_count
);
   import tlb_pkg::*;

   localparam int N = TLB_ENTRIES;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   // entry storage
   logic [N-1:0]        valid_ff, valid_in;
   logic [PAGE_W-1:0]   page_ff  [N];
   logic [FRAME_W-1:0]  frame_ff [N];
   logic [AGE_BITS-1:0] age_ff   [N];
   logic [AGE_BITS-1:0] age_in   [N];
   logic [PROC_W-1:0]   prev_proc_ff;

   // captured request
   logic [MODE_W-1:0]   mode_ff;
   logic [PROC_W-1:0]   proc_ff;
   logic [PAGE_W-1:0]   page_q_ff;
   logic [FRAME_W-1:0]  frame_q_ff;

   // scan stage
   logic                flush_w, flush_ff;
   logic [N-1:0]        match_w, match_ff;
   logic [N-1:0]        fmatch_w, fmatch_ff;
   logic [AGE_BITS-1:0] grp_age_w  [GROUPS];
   logic [AGE_BITS-1:0] grp_age_ff [GROUPS];
   logic [SLOT_W-1:0]   grp_idx_w  [GROUPS];
   logic [SLOT_W-1:0]   grp_idx_ff [GROUPS];

   // apply stage
   logic                hit_w;
   logic [SLOT_W-1:0]   hit_idx;
   logic                free_any;
   logic [SLOT_W-1:0]   free_idx;
   logic [AGE_BITS-1:0] max_age;
   logic [SLOT_W-1:0]   max_idx;
   logic [SLOT_W-1:0]   victim;
   logic [COUNT_W-1:0]  inv_count;
   logic                is_lookup, is_refill, is_inval;

   // result register
   logic                hit_ff;
   logic [FRAME_W-1:0]  hit_frame_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                flushed_ff;
   logic [COUNT_W-1:0]  count_ff;

   assign is_lookup = (mode_ff == MODE_LOOKUP);
   assign is_refill = (mode_ff == MODE_REFILL);
   assign is_inval  = (mode_ff == MODE_INVALIDATE);

   // ---- scan: tag compares and per-group oldest entry ----
   assign flush_w = is_lookup && (proc_ff != prev_proc_ff);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_w[i]  = valid_ff[i] && !flush_w && (page_ff[i] == page_q_ff);
         fmatch_w[i] = valid_ff[i] && (frame_ff[i] == frame_q_ff);
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_age_w[g] = age_ff[g*GRP_SIZE];
         grp_idx_w[g] = SLOT_W'(g*GRP_SIZE);
         for (int k = 1; k < GRP_SIZE; k++) begin
            // strict compare keeps the lowest index among equal ages
            if (age_ff[g*GRP_SIZE+k] > grp_age_w[g]) begin
               grp_age_w[g] = age_ff[g*GRP_SIZE+k];
               grp_idx_w[g] = SLOT_W'(g*GRP_SIZE+k);
            end
         end
      end
   end

   // ---- apply: pick slot, update entries ----
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = N-1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign hit_w    = |match_ff;
   assign free_any = ~&valid_ff;

   always_comb begin
      max_age = grp_age_ff[0];
      max_idx = grp_idx_ff[0];
      for (int g = 1; g < GROUPS; g++) begin
         if (grp_age_ff[g] > max_age) begin
            max_age = grp_age_ff[g];
            max_idx = grp_idx_ff[g];
         end
      end
   end

   assign victim    = free_any ? free_idx : max_idx;
   assign inv_count = COUNT_W'($countones(fmatch_ff));

   always_comb begin
      for (int i = 0; i < N; i++) begin
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         case (mode_ff)
            MODE_LOOKUP: begin
               if (flush_ff) begin
                  valid_in[i] = 1'b0;
                  age_in[i]   = '0;
               end else if (hit_w) begin
                  if (SLOT_W'(i) == hit_idx) begin
                     age_in[i] = '0;
                  end else if (valid_ff[i] && age_ff[i] != AGE_MAX) begin
                     age_in[i] = age_ff[i] + 1'b1;
                  end
               end
            end
            MODE_REFILL: begin
               if (SLOT_W'(i) == victim) begin
                  valid_in[i] = 1'b1;
                  age_in[i]   = '0;
               end else if (valid_ff[i] && age_ff[i] != AGE_MAX) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
            MODE_INVALIDATE: begin
               if (fmatch_ff[i]) begin
                  valid_in[i] = 1'b0;
                  age_in[i]   = '0;
               end
            end
            default: begin
               valid_in[i] = valid_ff[i];
            end
         endcase
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         prev_proc_ff <= PROC_NONE;
         for (int i = 0; i < N; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         for (int i = 0; i < N; i++) begin
            age_ff[i] <= age_in[i];
         end
         if (is_lookup) begin
            prev_proc_ff <= proc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_refill) begin
         page_ff[victim]  <= page_q_ff;
         frame_ff[victim] <= frame_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         proc_ff    <= req_process_id;
         page_q_ff  <= req_page_number;
         frame_q_ff <= req_frame_number;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         flush_ff  <= flush_w;
         match_ff  <= match_w;
         fmatch_ff <= fmatch_w;
         for (int g = 0; g < GROUPS; g++) begin
            grp_age_ff[g] <= grp_age_w[g];
            grp_idx_ff[g] <= grp_idx_w[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff       <= is_lookup && hit_w;
         hit_frame_ff <= (is_lookup && hit_w) ? frame_ff[hit_idx] : '0;
         slot_ff      <= (is_lookup && hit_w) ? hit_idx : (is_refill ? victim : '0);
         flushed_ff   <= is_lookup && flush_ff;
         count_ff     <= is_inval ? inv_count : '0;
      end
   end

   assign rsp_hit               = hit_ff;
   assign rsp_hit_frame         = hit_frame_ff;
   assign rsp_slot              = slot_ff;
   assign rsp_flushed           = flushed_ff;
   assign rsp_invalidated_count = count_ff;

endmodule

`default_nettype wire

@@ rtl/core/tlb_checker.sv @@
// Port-level assertions for the TLB top level, attached by bind.
`default_nettype none

module tlb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_hit,
   input wire logic [tlb_pkg::FRAME_W-1:0]   rsp_hit_frame,
   input wire logic [tlb_pkg::SLOT_W-1:0]    rsp_slot,
   input wire logic                          rsp_flushed,
   input wire logic [tlb_pkg::COUNT_W-1:0]   rsp_invalidated_count
);
   import tlb_pkg::*;

   // a stalled response stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one transaction in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // a miss reports no frame
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_frame == '0)
      else $error("hit_frame set without hit");

   // a flushing lookup cannot hit, and a hit is never an invalidate
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_flushed && rsp_invalidated_count == '0)
      else $error("hit combined with flush or invalidate");

   // invalidate reports no slot and never more than the entry count
   a_inval_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalidated_count != '0
         |-> rsp_slot == '0 && rsp_invalidated_count <= COUNT_W'(TLB_ENTRIES))
      else $error("bad invalidate response");

endmodule

bind tlb_lru_lookup_refill tlb_checker u_tlb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_if.valid),
   .req_ready             (req_if.ready),
   .rsp_valid             (rsp_if.valid),
   .rsp_ready             (rsp_if.ready),
   .rsp_hit               (rsp_if.hit),
   .rsp_hit_frame         (rsp_if.hit_frame),
   .rsp_slot              (rsp_if.slot),
   .rsp_flushed           (rsp_if.flushed),
   .rsp_invalidated_count (rsp_if.invalidated_count)
);

`default_nettype wire
